// ===== hdl/mfsgd_pkg.sv =====
// Shared types, codes, defaults and fixed-point helpers for the factorization update core.
package mfsgd_pkg;

    localparam int WORD_W = 32;
    localparam int IDX_W = 10;
    localparam int EL_W = 4;
    localparam int CFG_IDX_W = 3;

    localparam int DEF_NUM_USERS = 1024;
    localparam int DEF_NUM_ITEMS = 1024;
    localparam int DEF_MAX_DIMS = 16;
    localparam int DEF_VALUE_BITS = 32;

    localparam logic [1:0] OP_TRAIN = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [1:0] TBL_USER_FACTORS = 2'd0;
    localparam logic [1:0] TBL_ITEM_FACTORS = 2'd1;
    localparam logic [1:0] TBL_USER_BIAS = 2'd2;
    localparam logic [1:0] TBL_ITEM_BIAS = 2'd3;

    localparam logic [2:0] REG_DIMS = 3'd0;
    localparam logic [2:0] REG_STEP = 3'd1;
    localparam logic [2:0] REG_UF_DECAY = 3'd2;
    localparam logic [2:0] REG_IF_DECAY = 3'd3;
    localparam logic [2:0] REG_UB_DECAY = 3'd4;
    localparam logic [2:0] REG_IB_DECAY = 3'd5;
    localparam logic [2:0] REG_AVERAGE = 3'd6;
    localparam logic [2:0] REG_BIAS_EN = 3'd7;

    localparam logic [4:0] RST_DIMS = 5'd16;
    localparam logic [16:0] RST_STEP = 17'd66;
    localparam logic signed [31:0] RST_DECAY = 32'sd65536;

    typedef logic signed [63:0] wide_t;
    typedef logic signed [31:0] word_t;

    function automatic wide_t sadd(input wide_t a, input wide_t b);
        wide_t s;
        s = a + b;
        if (!a[63] && !b[63] && s[63])
        begin
            return {1'b0, {63{1'b1}}};
        end
        if (a[63] && b[63] && !s[63])
        begin
            return {1'b1, {63{1'b0}}};
        end
        return s;
    endfunction

    function automatic wide_t rnd(input wide_t x);
        wide_t y;
        y = sadd(x, 64'sd32768);
        return y >>> 16;
    endfunction

    function automatic wide_t satv(input wide_t x, input int bits);
        wide_t hi;
        wide_t lo;
        hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (x > hi)
        begin
            return hi;
        end
        if (x < lo)
        begin
            return lo;
        end
        return x;
    endfunction

    function automatic wide_t mul(input word_t a, input word_t b);
        wide_t wa;
        wide_t wb;
        wa = 64'(a);
        wb = 64'(b);
        return wa * wb;
    endfunction

endpackage

// ===== hdl/matrix_factorization_sgd_update_core.sv =====
// Top level of the matrix factorization SGD update core.
// A train word makes one pass over the factor memories for the dot product, then the error,
// gradient and bias arithmetic states S_ERR, S_MUL, S_GE and S_BIAS, then one read-modify-write
// pass over both factor rows; each pass issues one dimension per cycle through a two-stage pipe.
// A write word goes straight to S_DONE; a read word first passes S_RD for the registered read.
// Reset clears the control state and loads the register defaults; table contents stay undefined.
module matrix_factorization_sgd_update_core #(
    parameter int NUM_USERS = mfsgd_pkg::DEF_NUM_USERS,
    parameter int NUM_ITEMS = mfsgd_pkg::DEF_NUM_ITEMS,
    parameter int MAX_DIMS = mfsgd_pkg::DEF_MAX_DIMS,
    parameter int VALUE_BITS = mfsgd_pkg::DEF_VALUE_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // user_index[9:0], item_index[19:10], element_index[23:20], value[55:24]
    input  logic [55:0] s_axis_tdata,
    // opcode[1:0], table_select[3:2]
    input  logic [3:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[31:0], prediction_error[63:32], squared_error[95:64]
    output logic [95:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);

    localparam int UFD = NUM_USERS * MAX_DIMS;
    localparam int IFD = NUM_ITEMS * MAX_DIMS;
    localparam int UFAW = $clog2(UFD);
    localparam int IFAW = $clog2(IFD);
    localparam int UBAW = $clog2(NUM_USERS);
    localparam int IBAW = $clog2(NUM_ITEMS);
    localparam int DCW = $clog2(MAX_DIMS + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD = 4'd1;
    localparam logic [3:0] S_DOT = 4'd2;
    localparam logic [3:0] S_ERR = 4'd3;
    localparam logic [3:0] S_MUL = 4'd4;
    localparam logic [3:0] S_GE = 4'd5;
    localparam logic [3:0] S_BIAS = 4'd6;
    localparam logic [3:0] S_UPD = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    typedef logic [31:0] data_t;

    logic [3:0] state_reg, state_next;

    logic [4:0]  dims_cfg_reg;
    logic [16:0] step_reg;
    mfsgd_pkg::word_t ufd_reg, ifd_reg, ubd_reg, ibd_reg, avg_reg;
    logic [1:0]  bias_en_reg;

    logic [1:0] op_reg, tsel_reg;
    logic [mfsgd_pkg::IDX_W-1:0] u_reg, it_reg;
    mfsgd_pkg::word_t val_reg;
    logic rd_ok_reg, rd_ok_next;
    logic train_reg, train_next;
    logic [DCW-1:0] dims_reg;

    logic [DCW-1:0] cnt_reg, cnt_next, d1_reg, d2_reg;
    logic v1_reg, v1_next, v2_reg, v2_next;

    mfsgd_pkg::wide_t acc_reg, acc_next, prod_reg;
    mfsgd_pkg::wide_t pa_reg, pb_reg, pc_reg, pe_reg;
    mfsgd_pkg::wide_t sqp_reg, gep_reg, ubp_reg, ibp_reg;
    mfsgd_pkg::word_t err_reg, ge_reg;
    data_t sq_reg;

    logic out_valid_reg, out_valid_next;
    logic [95:0] out_data_reg;

    logic uf_we, if_we, ub_we, ib_we, uf_re, if_re, ub_re, ib_re;
    logic [UFAW-1:0] uf_waddr, uf_raddr;
    logic [IFAW-1:0] if_waddr, if_raddr;
    logic [UBAW-1:0] ub_addr;
    logic [IBAW-1:0] ib_addr;
    data_t uf_wdata, if_wdata, ub_wdata, ib_wdata;
    data_t uf_rdata, if_rdata, ub_rdata, ib_rdata;

    logic accept, issue, out_free;
    logic [1:0] in_op, in_tsel;
    logic [mfsgd_pkg::IDX_W-1:0] in_u, in_it;
    logic [mfsgd_pkg::EL_W-1:0] in_el;
    mfsgd_pkg::word_t in_val;
    logic u_ok, it_ok, el_ok;
    data_t in_sat;
    mfsgd_pkg::wide_t pred, p_new, q_new;
    data_t rd_sel;

    function automatic logic [UFAW-1:0] uaddr(input int row, input int d);
        return UFAW'(row * MAX_DIMS + d);
    endfunction

    function automatic logic [IFAW-1:0] iaddr(input int row, input int d);
        return IFAW'(row * MAX_DIMS + d);
    endfunction

    assign in_u = s_axis_tdata[9:0];
    assign in_it = s_axis_tdata[19:10];
    assign in_el = s_axis_tdata[23:20];
    assign in_val = s_axis_tdata[55:24];
    assign in_op = s_axis_tuser[1:0];
    assign in_tsel = s_axis_tuser[3:2];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;
    assign u_ok = (32'(in_u) < NUM_USERS);
    assign it_ok = (32'(in_it) < NUM_ITEMS);
    assign el_ok = (32'(in_el) < MAX_DIMS);
    assign in_sat = data_t'(mfsgd_pkg::satv(64'(in_val), VALUE_BITS));
    assign issue = ((state_reg == S_DOT) || (state_reg == S_UPD)) && (cnt_reg < dims_reg);
    assign out_free = !out_valid_reg || m_axis_tready;

    assign p_new = mfsgd_pkg::satv(mfsgd_pkg::rnd(mfsgd_pkg::sadd(pa_reg, pb_reg)), VALUE_BITS);
    assign q_new = mfsgd_pkg::satv(mfsgd_pkg::rnd(mfsgd_pkg::sadd(pc_reg, pe_reg)), VALUE_BITS);
    assign pred = mfsgd_pkg::rnd(acc_reg) + 64'(avg_reg)
                + (bias_en_reg[0] ? 64'($signed(ub_rdata)) : 64'sd0)
                + (bias_en_reg[1] ? 64'($signed(ib_rdata)) : 64'sd0);

    always_comb
    begin
        case (tsel_reg)
            mfsgd_pkg::TBL_USER_FACTORS: rd_sel = uf_rdata;
            mfsgd_pkg::TBL_ITEM_FACTORS: rd_sel = if_rdata;
            mfsgd_pkg::TBL_USER_BIAS:    rd_sel = ub_rdata;
            default:                     rd_sel = ib_rdata;
        endcase
    end

    always_comb
    begin
        uf_we = 1'b0;
        if_we = 1'b0;
        ub_we = 1'b0;
        ib_we = 1'b0;
        uf_re = 1'b0;
        if_re = 1'b0;
        ub_re = 1'b0;
        ib_re = 1'b0;
        uf_waddr = uaddr(32'(u_reg), 32'(d2_reg));
        if_waddr = iaddr(32'(it_reg), 32'(d2_reg));
        uf_raddr = uaddr(32'(u_reg), 32'(cnt_reg));
        if_raddr = iaddr(32'(it_reg), 32'(cnt_reg));
        ub_addr = UBAW'(u_reg);
        ib_addr = IBAW'(it_reg);
        uf_wdata = data_t'(p_new);
        if_wdata = data_t'(q_new);
        ub_wdata = data_t'(mfsgd_pkg::satv(mfsgd_pkg::rnd(ubp_reg) + 64'(ge_reg), VALUE_BITS));
        ib_wdata = data_t'(mfsgd_pkg::satv(mfsgd_pkg::rnd(ibp_reg) + 64'(ge_reg), VALUE_BITS));
        rd_ok_next = rd_ok_reg;
        train_next = train_reg;
        state_next = state_reg;
        cnt_next = cnt_reg;
        v1_next = issue;
        v2_next = v1_reg;
        acc_next = acc_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    uf_waddr = uaddr(32'(in_u), 32'(in_el));
                    if_waddr = iaddr(32'(in_it), 32'(in_el));
                    uf_raddr = uf_waddr;
                    if_raddr = if_waddr;
                    ub_addr = UBAW'(in_u);
                    ib_addr = IBAW'(in_it);
                    uf_wdata = in_sat;
                    if_wdata = in_sat;
                    ub_wdata = in_sat;
                    ib_wdata = in_sat;
                    rd_ok_next = 1'b0;
                    train_next = 1'b0;
                    state_next = S_DONE;
                    case (in_tsel)
                        mfsgd_pkg::TBL_USER_FACTORS: rd_ok_next = u_ok && el_ok;
                        mfsgd_pkg::TBL_ITEM_FACTORS: rd_ok_next = it_ok && el_ok;
                        mfsgd_pkg::TBL_USER_BIAS:    rd_ok_next = u_ok;
                        default:                     rd_ok_next = it_ok;
                    endcase
                    case (in_op)
                        mfsgd_pkg::OP_WRITE:
                        begin
                            uf_we = rd_ok_next && (in_tsel == mfsgd_pkg::TBL_USER_FACTORS);
                            if_we = rd_ok_next && (in_tsel == mfsgd_pkg::TBL_ITEM_FACTORS);
                            ub_we = rd_ok_next && (in_tsel == mfsgd_pkg::TBL_USER_BIAS);
                            ib_we = rd_ok_next && (in_tsel == mfsgd_pkg::TBL_ITEM_BIAS);
                            rd_ok_next = 1'b0;
                        end
                        mfsgd_pkg::OP_READ:
                        begin
                            uf_re = 1'b1;
                            if_re = 1'b1;
                            ub_re = 1'b1;
                            ib_re = 1'b1;
                            state_next = S_RD;
                        end
                        mfsgd_pkg::OP_TRAIN:
                        begin
                            rd_ok_next = 1'b0;
                            if (u_ok && it_ok)
                            begin
                                ub_re = 1'b1;
                                ib_re = 1'b1;
                                train_next = 1'b1;
                                cnt_next = '0;
                                acc_next = '0;
                                state_next = S_DOT;
                            end
                        end
                        default:
                        begin
                            rd_ok_next = 1'b0;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                state_next = S_DONE;
            end
            S_DOT:
            begin
                uf_re = issue;
                if_re = issue;
                if (issue)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (v2_reg)
                begin
                    acc_next = mfsgd_pkg::sadd(acc_reg, prod_reg);
                end
                if (!issue && !v1_reg && !v2_reg)
                begin
                    state_next = S_ERR;
                end
            end
            S_ERR:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_GE;
            end
            S_GE:
            begin
                state_next = S_BIAS;
            end
            S_BIAS:
            begin
                ub_we = bias_en_reg[0];
                ib_we = bias_en_reg[1];
                cnt_next = '0;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                uf_re = issue;
                if_re = issue;
                uf_we = v2_reg;
                if_we = v2_reg;
                if (issue)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (!issue && !v1_reg && !v2_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            cnt_reg <= '0;
            rd_ok_reg <= 1'b0;
            train_reg <= 1'b0;
            dims_cfg_reg <= mfsgd_pkg::RST_DIMS;
            step_reg <= mfsgd_pkg::RST_STEP;
            ufd_reg <= mfsgd_pkg::RST_DECAY;
            ifd_reg <= mfsgd_pkg::RST_DECAY;
            ubd_reg <= mfsgd_pkg::RST_DECAY;
            ibd_reg <= mfsgd_pkg::RST_DECAY;
            avg_reg <= '0;
            bias_en_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            cnt_reg <= cnt_next;
            rd_ok_reg <= rd_ok_next;
            train_reg <= train_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    mfsgd_pkg::REG_DIMS:     dims_cfg_reg <= cfg_wdata[4:0];
                    mfsgd_pkg::REG_STEP:     step_reg <= cfg_wdata[16:0];
                    mfsgd_pkg::REG_UF_DECAY: ufd_reg <= cfg_wdata;
                    mfsgd_pkg::REG_IF_DECAY: ifd_reg <= cfg_wdata;
                    mfsgd_pkg::REG_UB_DECAY: ubd_reg <= cfg_wdata;
                    mfsgd_pkg::REG_IB_DECAY: ibd_reg <= cfg_wdata;
                    mfsgd_pkg::REG_AVERAGE:  avg_reg <= cfg_wdata;
                    default:                 bias_en_reg <= cfg_wdata[1:0];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        d1_reg <= cnt_reg;
        d2_reg <= d1_reg;
        if (accept)
        begin
            op_reg <= in_op;
            tsel_reg <= in_tsel;
            u_reg <= in_u;
            it_reg <= in_it;
            val_reg <= in_val;
            dims_reg <= (32'(dims_cfg_reg) > MAX_DIMS) ? DCW'(MAX_DIMS) : DCW'(dims_cfg_reg);
        end
        prod_reg <= mfsgd_pkg::mul(uf_rdata, if_rdata);
        pa_reg <= mfsgd_pkg::mul(ge_reg, if_rdata);
        pb_reg <= mfsgd_pkg::mul(ufd_reg, uf_rdata);
        pc_reg <= mfsgd_pkg::mul(ge_reg, uf_rdata);
        pe_reg <= mfsgd_pkg::mul(ifd_reg, if_rdata);
        if (state_reg == S_ERR)
        begin
            err_reg <= mfsgd_pkg::word_t'(mfsgd_pkg::satv(64'(val_reg) - pred, VALUE_BITS));
        end
        if (state_reg == S_MUL)
        begin
            sqp_reg <= mfsgd_pkg::mul(err_reg, err_reg);
            gep_reg <= 64'(err_reg) * 64'($signed({15'd0, step_reg}));
            ubp_reg <= mfsgd_pkg::mul(ubd_reg, ub_rdata);
            ibp_reg <= mfsgd_pkg::mul(ibd_reg, ib_rdata);
        end
        if (state_reg == S_GE)
        begin
            sq_reg <= (mfsgd_pkg::rnd(sqp_reg) > 64'sh0FFFFFFFF) ? 32'hFFFFFFFF
                    : data_t'(mfsgd_pkg::rnd(sqp_reg));
            ge_reg <= mfsgd_pkg::word_t'(mfsgd_pkg::satv(mfsgd_pkg::rnd(gep_reg), VALUE_BITS));
        end
        if ((state_reg == S_DONE) && out_free)
        begin
            out_data_reg[31:0] <= (rd_ok_reg && (op_reg == mfsgd_pkg::OP_READ)) ? rd_sel : '0;
            out_data_reg[63:32] <= train_reg ? err_reg : '0;
            out_data_reg[95:64] <= train_reg ? sq_reg : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;

    mfsgd_ram #(.DEPTH(UFD), .AW(UFAW)) u_uf_ram (
        .clk(clk), .we(uf_we), .waddr(uf_waddr), .wdata(uf_wdata),
        .re(uf_re), .raddr(uf_raddr), .rdata(uf_rdata)
    );

    mfsgd_ram #(.DEPTH(IFD), .AW(IFAW)) u_if_ram (
        .clk(clk), .we(if_we), .waddr(if_waddr), .wdata(if_wdata),
        .re(if_re), .raddr(if_raddr), .rdata(if_rdata)
    );

    mfsgd_ram #(.DEPTH(NUM_USERS), .AW(UBAW)) u_ub_ram (
        .clk(clk), .we(ub_we), .waddr(ub_addr), .wdata(ub_wdata),
        .re(ub_re), .raddr(ub_addr), .rdata(ub_rdata)
    );

    mfsgd_ram #(.DEPTH(NUM_ITEMS), .AW(IBAW)) u_ib_ram (
        .clk(clk), .we(ib_we), .waddr(ib_addr), .wdata(ib_wdata),
        .re(ib_re), .raddr(ib_addr), .rdata(ib_rdata)
    );

endmodule

// ===== hdl/mfsgd_ram.sv =====
// Single-port-write, single-port-read table memory with registered read data.
module mfsgd_ram #(
    parameter int DEPTH = 1024,
    parameter int AW = 10
) (
    input  logic                            clk,
    input  logic                            we,
    input  logic [AW-1:0]                   waddr,
    input  logic [mfsgd_pkg::WORD_W-1:0]    wdata,
    input  logic                            re,
    input  logic [AW-1:0]                   raddr,
    output logic [mfsgd_pkg::WORD_W-1:0]    rdata
);

    logic [mfsgd_pkg::WORD_W-1:0] mem [DEPTH];
    logic [mfsgd_pkg::WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/mfsgd_checker.sv =====
// Port-level checks for the factorization update core, bound to the top level.
module mfsgd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata
);

    assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("Output word valid during reset.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("Output word dropped before it was taken.");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("Input taken while the previous word was still in work.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[31:0] != 32'd0) |->
        (m_axis_tdata[63:32] == 32'd0) && (m_axis_tdata[95:64] == 32'd0))
        else $error("Read data and training error in the same word.");

endmodule

bind matrix_factorization_sgd_update_core mfsgd_checker u_mfsgd_checker (
    .clk(clk),
    .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
